FILE: rtl/hplm_pkg.sv
package hplm_pkg;

  typedef struct packed {
    logic        command;
    logic [7:0]  cell_rho;
    logic [6:0]  cell_theta;
    logic [15:0] cell_votes;
  } hplm_in_t;

  typedef struct packed {
    logic        peak_valid;
    logic [7:0]  peak_rho;
    logic [6:0]  peak_theta;
    logic [15:0] peak_votes;
    logic        last_peak;
  } hplm_out_t;

  typedef struct packed {
    logic [15:0] vote_threshold;
    logic [3:0]  window_radius;
    logic [4:0]  max_peaks;
    logic [8:0]  rho_bins_used;
    logic [7:0]  theta_bins_used;
  } hplm_cfg_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_FIND = 1'b1;

  localparam logic [2:0] REG_THRESH = 3'd0;
  localparam logic [2:0] REG_RADIUS = 3'd1;
  localparam logic [2:0] REG_MAXPK  = 3'd2;
  localparam logic [2:0] REG_ROWS   = 3'd3;
  localparam logic [2:0] REG_COLS   = 3'd4;

endpackage

FILE: rtl/hplm_regs.sv
module hplm_regs
  import hplm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output hplm_cfg_t   cfg_o
);

  hplm_cfg_t cfg_q;
  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vote_threshold  <= 16'd100;
      cfg_q.window_radius   <= 4'd2;
      cfg_q.max_peaks       <= 5'd10;
      cfg_q.rho_bins_used   <= 9'd256;
      cfg_q.theta_bins_used <= 8'd128;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_THRESH: cfg_q.vote_threshold  <= pwdata[15:0];
        REG_RADIUS: cfg_q.window_radius   <= pwdata[3:0];
        REG_MAXPK:  cfg_q.max_peaks       <= pwdata[4:0];
        REG_ROWS:   cfg_q.rho_bins_used   <= pwdata[8:0];
        REG_COLS:   cfg_q.theta_bins_used <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_THRESH: prdata[15:0] = cfg_q.vote_threshold;
      REG_RADIUS: prdata[3:0]  = cfg_q.window_radius;
      REG_MAXPK:  prdata[4:0]  = cfg_q.max_peaks;
      REG_ROWS:   prdata[8:0]  = cfg_q.rho_bins_used;
      REG_COLS:   prdata[7:0]  = cfg_q.theta_bins_used;
      default: ;
    endcase
  end

endmodule

FILE: rtl/hough_peak_local_max_topk.sv
// Hough peak finder with local-maximum suppression and top-k selection.
// Input channel (in_valid_i/in_ready_o/in_data_i): a load transfer writes one
// accumulator cell at the accepting edge, so loads can follow back to back;
// a find transfer scans the used area.
// Output channel (out_valid_o/out_ready_i/out_data_o): a find returns up to
// max_peaks results in descending vote order, last_peak on the final one, or
// one result with peak_valid low when no cell qualifies.
// Find steps: a setup state, then for each cell a read, a check and a step;
// a cell at or above threshold adds a read and a check per window cell
// (stopping at the first larger neighbor) and, when it is a local max, one
// kept slot compared per cycle, then the insert. All time is set by the single
// read port of the vote memory. The first result is registered in the output
// state after the scan, then results go out one per cycle while ready is high.
// The block takes no new item until all results of a find are transferred;
// a stalled receiver simply holds the output register.
// Reset clears control state and loads register defaults; the vote memory
// is not cleared and every used cell must be loaded before a find.
// Registers over APB at 4*i: threshold, radius, max_peaks, rho/theta used.
module hough_peak_local_max_topk
  import hplm_pkg::*;
#(
  parameter int RHO_BINS        = 256,
  parameter int THETA_BINS      = 128,
  parameter int MAX_PEAKS_LIMIT = 16,
  parameter int VOTE_BITS       = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  hplm_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output hplm_out_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RW = (RHO_BINS > 1) ? $clog2(RHO_BINS) : 1;
  localparam int TW = (THETA_BINS > 1) ? $clog2(THETA_BINS) : 1;
  localparam int AW = RW + TW;
  localparam int KW = (MAX_PEAKS_LIMIT > 1) ? $clog2(MAX_PEAKS_LIMIT) : 1;
  localparam int CW = $clog2(MAX_PEAKS_LIMIT + 1);
  localparam int RC = RW + 2;  // row coord with two spare bits
  localparam int TC = TW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_CRD, S_CCHK, S_NRD, S_NCHK, S_INS, S_NEXT, S_OUT
  } state_e;

  hplm_cfg_t cfg;

  hplm_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  logic [VOTE_BITS-1:0] mem_q [RHO_BINS*THETA_BINS];
  logic [VOTE_BITS-1:0] rd_q;
  logic [AW-1:0]        raddr;
  logic                 we;
  logic [AW-1:0]        waddr;

  state_e state_q;
  logic [RC-1:0] rows_q, r_q, nr_q, rhi_q;
  logic [TC-1:0] cols_q, t_q, nt_q, tlo_q, thi_q;
  logic [CW-1:0] k_q, cnt_q, pos_q, oi_q;
  logic [VOTE_BITS-1:0] cv_q;
  logic [VOTE_BITS-1:0] bv_q [MAX_PEAKS_LIMIT];
  logic [AW-1:0]        bi_q [MAX_PEAKS_LIMIT];
  hplm_out_t out_q;
  logic      ov_q;

  logic in_fire;
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  assign we    = in_fire && (in_data_i.command == CMD_LOAD) &&
                 ({1'b0, in_data_i.cell_rho} < 9'(RHO_BINS < 256 ? RHO_BINS : 256)) &&
                 ({1'b0, in_data_i.cell_theta} < 8'(THETA_BINS < 128 ? THETA_BINS : 128));
  assign waddr = AW'(in_data_i.cell_rho) * AW'(THETA_BINS) + AW'(in_data_i.cell_theta);

  always_comb begin
    if (state_q == S_NRD)
      raddr = AW'(nr_q) * AW'(THETA_BINS) + AW'(nt_q);
    else
      raddr = AW'(r_q) * AW'(THETA_BINS) + AW'(t_q);
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= VOTE_BITS'(in_data_i.cell_votes);
    rd_q <= mem_q[raddr];
  end

  // window bounds
  logic [RC-1:0] rlo_c, rhi_c;
  logic [TC-1:0] tlo_c, thi_c;
  always_comb begin
    rlo_c = (r_q >= RC'(cfg.window_radius)) ? r_q - RC'(cfg.window_radius) : '0;
    rhi_c = (r_q + RC'(cfg.window_radius) > rows_q - 1'b1) ? rows_q - 1'b1
                                                         : r_q + RC'(cfg.window_radius);
    tlo_c = (t_q >= TC'(cfg.window_radius)) ? t_q - TC'(cfg.window_radius) : '0;
    thi_c = (t_q + TC'(cfg.window_radius) > cols_q - 1'b1) ? cols_q - 1'b1
                                                         : t_q + TC'(cfg.window_radius);
  end

  logic [CW-1:0] kc;
  logic [RC-1:0] rows_c;
  logic [TC-1:0] cols_c;
  always_comb begin
    kc = (cfg.max_peaks == 5'd0) ? CW'(1) :
         (32'(cfg.max_peaks) > MAX_PEAKS_LIMIT) ? CW'(MAX_PEAKS_LIMIT) : CW'(cfg.max_peaks);
    rows_c = (32'(cfg.rho_bins_used) > RHO_BINS) ? RC'(RHO_BINS) : RC'(cfg.rho_bins_used);
    cols_c = (32'(cfg.theta_bins_used) > THETA_BINS) ? TC'(THETA_BINS)
                                                     : TC'(cfg.theta_bins_used);
  end

  logic [KW-1:0] pidx;
  assign pidx = pos_q[KW-1:0];
  logic [KW-1:0] oidx;
  assign oidx = oi_q[KW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_fire && in_data_i.command == CMD_FIND) begin
            rows_q <= rows_c; cols_q <= cols_c; k_q <= kc;
            cnt_q <= '0; r_q <= '0; t_q <= '0;
            state_q <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (rows_q == '0 || cols_q == '0) begin
            oi_q <= '0; state_q <= S_OUT;
          end else state_q <= S_CRD;
        end
        S_CRD: state_q <= S_CCHK;
        S_CCHK: begin
          cv_q <= rd_q;
          if (32'(rd_q) < 32'(cfg.vote_threshold)) state_q <= S_NEXT;
          else begin
            nr_q <= rlo_c; rhi_q <= rhi_c; nt_q <= tlo_c;
            tlo_q <= tlo_c; thi_q <= thi_c;
            state_q <= S_NRD;
          end
        end
        S_NRD: state_q <= S_NCHK;
        S_NCHK: begin
          if (rd_q > cv_q) state_q <= S_NEXT;
          else if (nt_q == thi_q) begin
            if (nr_q == rhi_q) begin pos_q <= '0; state_q <= S_INS; end
            else begin nr_q <= nr_q + 1'b1; nt_q <= tlo_q; state_q <= S_NRD; end
          end else begin nt_q <= nt_q + 1'b1; state_q <= S_NRD; end
        end
        S_INS: begin
          // one slot compared per cycle
          if (pos_q < cnt_q && bv_q[pidx] >= cv_q) pos_q <= pos_q + 1'b1;
          else begin
            if (pos_q < k_q) begin
              for (int i = MAX_PEAKS_LIMIT - 1; i > 0; i--) begin
                if (CW'(i) > pos_q) begin
                  bv_q[i] <= bv_q[i-1]; bi_q[i] <= bi_q[i-1];
                end
              end
              bv_q[pidx] <= cv_q;
              // row and column kept as separate fields of the index
              bi_q[pidx] <= {r_q[RW-1:0], t_q[TW-1:0]};
              if (cnt_q < k_q) cnt_q <= cnt_q + 1'b1;
            end
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (t_q == cols_q - 1'b1) begin
            t_q <= '0;
            if (r_q == rows_q - 1'b1) begin oi_q <= '0; state_q <= S_OUT; end
            else begin r_q <= r_q + 1'b1; state_q <= S_CRD; end
          end else begin t_q <= t_q + 1'b1; state_q <= S_CRD; end
        end
        S_OUT: begin
          if (!ov_q || out_ready_i) begin
            if (oi_q == cnt_q && cnt_q != '0) begin
              ov_q <= 1'b0; state_q <= S_IDLE;
            end else if (cnt_q == '0 && oi_q != '0) begin
              ov_q <= 1'b0; state_q <= S_IDLE;
            end else begin
              ov_q <= 1'b1;
              if (cnt_q == '0) begin
                out_q <= '{peak_valid: 1'b0, peak_rho: '0, peak_theta: '0,
                           peak_votes: '0, last_peak: 1'b1};
              end else begin
                out_q.peak_valid <= 1'b1;
                out_q.peak_rho   <= 8'(bi_q[oidx][AW-1:TW]);
                out_q.peak_theta <= 7'(bi_q[oidx][TW-1:0]);
                out_q.peak_votes <= 16'(bv_q[oidx]);
                out_q.last_peak  <= (oi_q + 1'b1 == cnt_q);
              end
              oi_q <= oi_q + 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
